@@ rtl/npp_pkg.sv @@
package npp_pkg;

  localparam int CW        = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_CHUNK = 17;
  localparam int MUL_LAT   = 3;

  localparam logic [1:0] MODE_POINT = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_PLANE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_ANCHOR_X = 3'd1,
    REG_ANCHOR_Y = 3'd2,
    REG_ANCHOR_Z = 3'd3,
    REG_DIR_X    = 3'd4,
    REG_DIR_Y    = 3'd5,
    REG_DIR_Z    = 3'd6
  } cfg_reg_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } in_t;

  typedef struct packed {
    coord_t near_x;
    coord_t near_y;
    coord_t near_z;
    logic   degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0]         pneg;
    logic               nneg;
  } side_t;

endpackage

@@ rtl/npp_mul.sv @@
module npp_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod
);
  import npp_pkg::*;

  localparam int CH = MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int RW = AW + CH;
  localparam int PW = AW + BW;

  logic [NA*CH-1:0] a_ext;
  logic [NB*CH-1:0] b_ext;
  logic [2*CH-1:0]  pp_r   [NA][NB];
  logic [2*CH-1:0]  pp_nxt [NA][NB];
  logic [RW-1:0]    row_r  [NB];
  logic [RW-1:0]    row_nxt[NB];
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_nxt;

  assign a_ext = (NA*CH)'(a);
  assign b_ext = (NB*CH)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = (2*CH)'(a_ext[i*CH +: CH]) * (2*CH)'(b_ext[j*CH +: CH]);
      end
    end
  end

  // rows: full a times one chunk of b
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_nxt[j] = row_nxt[j] + (RW'(pp_r[i][j]) << (i*CH));
      end
    end
  end

  always_comb begin
    prod_nxt = '0;
    for (int j = 0; j < NB; j++) begin
      prod_nxt = prod_nxt + (PW'(row_r[j]) << (j*CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r   <= pp_nxt;
      row_r  <= row_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/npp_div.sv @@
module npp_div #(
  parameter int QW = 33,
  parameter int DW = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo,
  output logic [DW-1:0]    rem
);

  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] rem_nxt[QW];
  logic [QW-1:0] q_r    [QW];
  logic [QW-1:0] q_nxt  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [QW-1:0] lo_nxt [QW];

  // one quotient bit per stage; the top part of num is already below den
  always_comb begin
    logic [DW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] lo_in;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_in = num[DW+QW-1:QW];
        q_in   = '0;
        lo_in  = num[QW-1:0];
      end else begin
        rem_in = rem_r[k-1];
        q_in   = q_r[k-1];
        lo_in  = lo_r[k-1];
      end
      trial      = {rem_in, lo_in[QW-1]};
      ge         = trial >= {1'b0, den};
      rem_nxt[k] = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
      q_nxt[k]   = {q_in[QW-2:0], ge};
      lo_nxt[k]  = lo_in << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign quo = q_r[QW-1];
  assign rem = rem_r[QW-1];

endmodule

@@ rtl/nearest_point_projection.sv @@
// Throughput: one transaction per cycle while the output is not stalled; depth is set by the bit-per-stage divider.
// A stalled valid output holds the whole pipeline; no bubble is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and zeroes the configuration
// registers; there is no clearing pass.
module nearest_point_projection (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [npp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [npp_pkg::CW-1:0]         cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  npp_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output npp_pkg::out_t                  out_data
);
  import npp_pkg::*;

  localparam int QW      = CW + 1;
  localparam int DW      = 2*CW;
  localparam int P1W     = 2*CW + 1;
  localparam int NUMW    = 2*CW + 2;
  localparam int NMW     = 2*CW + 1;
  localparam int P2W     = 3*CW + 1;
  localparam int P_MAG   = 1;
  localparam int P_PROD1 = P_MAG + MUL_LAT;
  localparam int P_NUM   = P_PROD1 + 1;
  localparam int P_NMAG  = P_NUM + 1;
  localparam int P_PROD2 = P_NMAG + MUL_LAT;
  localparam int P_QUO   = P_PROD2 + QW;
  localparam int P_RND   = P_QUO + 1;
  localparam int LAST    = P_RND + 1;

  logic [1:0]        mode_r, mode_nxt;
  coord_t            anc_r  [3];
  coord_t            anc_nxt[3];
  coord_t            dir_r  [3];
  coord_t            dir_nxt[3];

  logic [CW-1:0]     dmag_r [3];
  logic [DW-1:0]     dsq    [3];
  logic [DW-1:0]     den_r;
  logic              den_zero_r;

  logic              adv;
  logic [LAST:0]     vld_r, vld_nxt;
  side_t             side_r  [LAST+1];
  side_t             side_nxt[LAST+1];

  coord_t            qry    [3];
  logic [CW:0]       v_r    [3];
  logic [CW:0]       v_nxt  [3];
  logic [CW:0]       vmag_r [3];
  logic [CW:0]       vmag_nxt[3];
  logic [P1W-1:0]    prod1  [3];
  logic [NUMW-1:0]   num_r, num_nxt;
  logic [NMW-1:0]    nmag_r, nmag_nxt;
  logic [P2W-1:0]    prod2  [3];
  logic [QW-1:0]     quo    [3];
  logic [DW-1:0]     rem    [3];
  logic [QW-1:0]     qr_r   [3];
  logic [QW-1:0]     qr_nxt [3];
  out_t              out_r, out_nxt;

  // configuration write port
  always_comb begin
    mode_nxt = mode_r;
    anc_nxt  = anc_r;
    dir_nxt  = dir_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:     mode_nxt   = cfg_wdata[1:0];
        REG_ANCHOR_X: anc_nxt[0] = cfg_wdata;
        REG_ANCHOR_Y: anc_nxt[1] = cfg_wdata;
        REG_ANCHOR_Z: anc_nxt[2] = cfg_wdata;
        REG_DIR_X:    dir_nxt[0] = cfg_wdata;
        REG_DIR_Y:    dir_nxt[1] = cfg_wdata;
        REG_DIR_Z:    dir_nxt[2] = cfg_wdata;
        default:      ;
      endcase
    end
  end

  // direction terms run free; they settle long before an item needs them
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dmag_r[i] <= dir_r[i][CW-1] ? ($unsigned(~dir_r[i]) + CW'(1)) : $unsigned(dir_r[i]);
    end
    den_r      <= dsq[0] + dsq[1] + dsq[2];
    den_zero_r <= den_r == '0;
  end

  for (genvar i = 0; i < 3; i++) begin : g_dsq
    npp_mul #(.AW(CW), .BW(CW)) u_dsq (
      .clk  (clk),
      .en   (1'b1),
      .a    (dmag_r[i]),
      .b    (dmag_r[i]),
      .prod (dsq[i])
    );
  end

  assign adv       = !vld_r[LAST] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAST];
  assign out_data  = out_r;
  assign vld_nxt   = {vld_r[LAST-1:0], in_valid};

  assign qry[0] = in_data.query_x;
  assign qry[1] = in_data.query_y;
  assign qry[2] = in_data.query_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_nxt[i]    = {qry[i][CW-1], qry[i]} - {anc_r[i][CW-1], anc_r[i]};
      vmag_nxt[i] = v_r[i][CW] ? (~v_r[i] + (CW+1)'(1)) : v_r[i];
    end
  end

  // sideband: query point and sign bits travel with the item
  always_comb begin
    side_nxt[0].p[0] = qry[0];
    side_nxt[0].p[1] = qry[1];
    side_nxt[0].p[2] = qry[2];
    side_nxt[0].pneg = '0;
    side_nxt[0].nneg = 1'b0;
    for (int k = 1; k <= LAST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      side_nxt[P_MAG].pneg[i] = v_r[i][CW] ^ dir_r[i][CW-1];
    end
    side_nxt[P_NMAG].nneg = num_r[NUMW-1];
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    npp_mul #(.AW(CW+1), .BW(CW)) u_mul_dv (
      .clk  (clk),
      .en   (adv),
      .a    (vmag_r[i]),
      .b    (dmag_r[i]),
      .prod (prod1[i])
    );

    npp_mul #(.AW(NMW), .BW(CW)) u_mul_dn (
      .clk  (clk),
      .en   (adv),
      .a    (nmag_r),
      .b    (dmag_r[i]),
      .prod (prod2[i])
    );

    npp_div #(.QW(QW), .DW(DW)) u_div (
      .clk  (clk),
      .en   (adv),
      .num  (prod2[i]),
      .den  (den_r),
      .quo  (quo[i]),
      .rem  (rem[i])
    );
  end

  always_comb begin
    logic [NUMW-1:0] term;
    num_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      term    = {1'b0, prod1[i]};
      num_nxt = num_nxt + (side_r[P_PROD1].pneg[i] ? (~term + NUMW'(1)) : term);
    end
    nmag_nxt = num_r[NUMW-1] ? NMW'(~num_r + NUMW'(1)) : NMW'(num_r);
  end

  // round half away from zero on the magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr_nxt[i] = quo[i] + QW'({rem[i], 1'b0} >= {1'b0, den_r});
    end
  end

  always_comb begin
    logic [CW+2:0] qext;
    logic [CW+2:0] off;
    logic [CW+2:0] a_w;
    logic [CW+2:0] p_w;
    logic [CW+2:0] sum_w;
    coord_t        sat [3];
    coord_t        res [3];
    logic          degen;
    for (int i = 0; i < 3; i++) begin
      qext  = {2'b00, qr_r[i]};
      off   = (dir_r[i][CW-1] ^ side_r[P_RND].nneg) ? (~qext + (CW+3)'(1)) : qext;
      a_w   = {{3{anc_r[i][CW-1]}}, anc_r[i]};
      p_w   = {{3{side_r[P_RND].p[i][CW-1]}}, side_r[P_RND].p[i]};
      sum_w = (mode_r == MODE_LINE) ? (a_w + off) : (p_w - off);
      if (sum_w[CW+2:CW-1] == '0 || sum_w[CW+2:CW-1] == '1) begin
        sat[i] = sum_w[CW-1:0];
      end else if (sum_w[CW+2]) begin
        sat[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    degen = 1'b0;
    case (mode_r) inside
      MODE_LINE, MODE_PLANE: begin
        if (den_zero_r) begin
          degen = 1'b1;
          for (int i = 0; i < 3; i++) begin
            res[i] = (mode_r == MODE_LINE) ? anc_r[i] : coord_t'(side_r[P_RND].p[i]);
          end
        end else begin
          res = sat;
        end
      end
      default: res = anc_r;
    endcase
    out_nxt.near_x     = res[0];
    out_nxt.near_y     = res[1];
    out_nxt.near_z     = res[2];
    out_nxt.degenerate = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mode_r <= MODE_POINT;
      for (int i = 0; i < 3; i++) begin
        anc_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      anc_r  <= anc_nxt;
      dir_r  <= dir_nxt;
      if (adv) begin
        vld_r <= vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
      v_r    <= v_nxt;
      vmag_r <= vmag_nxt;
      num_r  <= num_nxt;
      nmag_r <= nmag_nxt;
      qr_r   <= qr_nxt;
      out_r  <= out_nxt;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valids moved while stalled");

  a_drain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> vld_r[LAST] == $past(vld_r[LAST-1]))
    else $error("output stage did not take the next stage");

endmodule

@@ tb/nearest_point_projection_test.sv @@
module nearest_point_projection_test;
  import npp_pkg::*;

  localparam int LATENCY = 44;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CW-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  nearest_point_projection u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // shadow configuration
  logic [1:0] mode_q;
  logic signed [CW-1:0] anchor_q [3];
  logic signed [CW-1:0] dir_q [3];

  out_t near_queue[$];
  int mismatches;
  longint cycles;
  bit calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] clamp_coord(logic signed [255:0] v);
    logic signed [255:0] hi;
    logic signed [255:0] lo;
    hi = (256'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // exact projection with half-away-from-zero rounding
  function automatic out_t project_point(in_t q);
    out_t r;
    logic signed [255:0] p [3];
    logic signed [255:0] a [3];
    logic signed [255:0] d [3];
    logic signed [255:0] num;
    logic signed [255:0] den;
    logic signed [255:0] prod;
    logic signed [255:0] mag;
    logic signed [255:0] quo;
    logic signed [255:0] rem;
    logic signed [255:0] res [3];
    p[0] = q.query_x;
    p[1] = q.query_y;
    p[2] = q.query_z;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = anchor_q[i];
      d[i] = dir_q[i];
      res[i] = a[i];
      num += d[i] * (p[i] - a[i]);
      den += d[i] * d[i];
    end
    r.degenerate = 1'b0;
    if (mode_q == MODE_LINE || mode_q == MODE_PLANE) begin
      if (den == 0) begin
        r.degenerate = 1'b1;
        for (int i = 0; i < 3; i++) res[i] = (mode_q == MODE_LINE) ? a[i] : p[i];
      end else begin
        for (int i = 0; i < 3; i++) begin
          prod = d[i] * num;
          mag = (prod < 0) ? -prod : prod;
          quo = mag / den;
          rem = mag % den;
          if (2 * rem >= den) quo += 1;
          if (quo > (256'sd1 <<< 62)) quo = 256'sd1 <<< 62;
          if (prod < 0) quo = -quo;
          res[i] = (mode_q == MODE_LINE) ? a[i] + quo : p[i] - quo;
        end
      end
    end
    r.near_x = clamp_coord(res[0]);
    r.near_y = clamp_coord(res[1]);
    r.near_z = clamp_coord(res[2]);
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: mode_q = val[1:0];
      REG_ANCHOR_X, REG_ANCHOR_Y, REG_ANCHOR_Z: anchor_q[idx - REG_ANCHOR_X] = val;
      default: dir_q[idx - REG_DIR_X] = val;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (near_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_attractor(logic [1:0] m, logic [CW-1:0] ax, logic [CW-1:0] ay,
                               logic [CW-1:0] az, logic [CW-1:0] dx, logic [CW-1:0] dy,
                               logic [CW-1:0] dz);
    drain();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_ANCHOR_X, ax);
    write_reg(REG_ANCHOR_Y, ay);
    write_reg(REG_ANCHOR_Z, az);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_query(in_t q);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_data <= in_t'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    near_queue.push_back(project_point(q));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_t want;
      if (near_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        mismatches++;
      end else begin
        want = near_queue.pop_front();
        if (out_data.near_x !== want.near_x)
          $display("%0t near_x exp %h got %h", $time, want.near_x, out_data.near_x);
        if (out_data.near_y !== want.near_y)
          $display("%0t near_y exp %h got %h", $time, want.near_y, out_data.near_y);
        if (out_data.near_z !== want.near_z)
          $display("%0t near_z exp %h got %h", $time, want.near_z, out_data.near_z);
        if (out_data.degenerate !== want.degenerate)
          $display("%0t degenerate exp %b got %b", $time, want.degenerate, out_data.degenerate);
        if (out_data !== want) mismatches++;
      end
    end
  end

  // receiver stalls in short bursts
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (!out_stall && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 3)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 4096)) - 2048) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_query();
    return '{pick_coord(), pick_coord(), pick_coord()};
  endfunction

  task automatic test_point_mode;
    set_attractor(MODE_POINT, 32'h0001_8000, 32'hffff_0000, 32'h7fff_ffff, 32'h1, 32'h2, 32'h3);
    send_query('{32'h8000_0000, 32'h7fff_ffff, 32'h0});
    send_query('{32'hffff_ffff, 32'h0, 32'h8000_0000});
    drain();
    write_reg(REG_MODE, 32'd3);
    send_query('{32'h1234_5678, 32'h8765_4321, 32'h0});
  endtask

  task automatic test_degenerate;
    set_attractor(MODE_LINE, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    send_query('{32'h7fff_ffff, 32'h8000_0000, 32'h1});
    set_attractor(MODE_PLANE, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_query('{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff});
  endtask

  task automatic test_extremes;
    set_attractor(MODE_LINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h1);
    send_query('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_query('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    set_attractor(MODE_PLANE, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_query('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_query('{32'h0, 32'h0, 32'h0});
    set_attractor(MODE_LINE, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0);
    // ties in the rounding
    send_query('{32'h1, 32'h0, 32'h0});
    send_query('{32'hffff_ffff, 32'h0, 32'h0});
    send_query('{32'h3, 32'h0, 32'h7fff_ffff});
  endtask

  task automatic test_random_streams;
    for (int phase = 0; phase < 12; phase++) begin
      set_attractor(2'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord(),
                    ($urandom_range(0, 9) == 0) ? 32'h0 : pick_coord(),
                    pick_coord(), pick_coord());
      if (phase == 11) calm = 1'b1;
      for (int n = 0; n < 75; n++) send_query(random_query());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    mode_q = MODE_POINT;
    for (int i = 0; i < 3; i++) begin
      anchor_q[i] = '0;
      dir_q[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_point_mode();
    test_degenerate();
    test_extremes();
    test_random_streams();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
